@@ rtl/mqsb_pkg.sv @@
package mqsb_pkg;

	// Store geometry.
	localparam int SLOTS  = 16;
	localparam int QUEUES = 4;
	localparam int DATA_W = 32;

	// A pointer holds a slot number or the null value SLOTS.
	localparam int PTR_W  = $clog2(SLOTS + 1);
	localparam int SIDX_W = $clog2(SLOTS);
	localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [SIDX_W-1:0] sidx_t;
	typedef logic [QIDX_W-1:0] qidx_t;

	localparam ptr_t NIL = PTR_W'(SLOTS);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BADQ  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	// Access request to the link store.
	typedef struct packed {
		logic  re;
		sidx_t raddr;
		logic  we;
		sidx_t waddr;
		ptr_t  wdata;
	} link_req_t;

	function automatic logic is_slot(ptr_t p);
		is_slot = (p < NIL);
	endfunction

endpackage

@@ rtl/mqsb_req_if.sv @@
interface mqsb_req_if
	import mqsb_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [1:0]         queue_id;
	logic signed [31:0] data_in;

	modport source (output valid, output kind, output queue_id, output data_in, input ready);
	modport sink   (input valid, input kind, input queue_id, input data_in, output ready);
endinterface

@@ rtl/mqsb_rsp_if.sv @@
interface mqsb_rsp_if
	import mqsb_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data_out;

	modport source (output valid, output status, output data_out, input ready);
	modport sink   (input valid, input status, input data_out, output ready);
endinterface

@@ rtl/mqsb_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module mqsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/mqsb_link_store.sv @@
// Slot link memory. A slot that has never been written reads as its reset
// link, the next slot number, so the free list starts as one chain.
module mqsb_link_store
	import mqsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  link_req_t req,
	output ptr_t      rdata
);
	logic [SLOTS-1:0] vld_q;
	logic             vld_s1;
	ptr_t             dflt_s1;
	ptr_t             ram_rdata;

	mqsb_ram #(
		.WIDTH(PTR_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (req.we),
		.waddr(req.waddr),
		.wdata(req.wdata),
		.re   (req.re),
		.raddr(req.raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			vld_s1  <= vld_q[req.raddr];
			dflt_s1 <= PTR_W'(req.raddr) + PTR_W'(1);
		end
	end

	assign rdata = vld_s1 ? ram_rdata : dflt_s1;
endmodule

@@ rtl/multi_queue_shared_buffer_top.sv @@
// The request moves to EXEC when it is accepted, and EXEC loads the result word into the result register
// when that register is free; a stalled result holds the request in EXEC until it drains.
// A new request is taken only after the current one leaves EXEC; the link memory read launched at
// acceptance feeds the pointer and link writeback in EXEC, which the next request needs.
// Reset: all queues empty, every slot on the free list in order, no clearing pass;
// slot data is undefined until an enqueue writes it.
module multi_queue_shared_buffer_top
	import mqsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mqsb_req_if.sink   req,
	mqsb_rsp_if.source rsp
);
	// Two-step sequencer: IDLE takes a request and launches the memory reads,
	// EXEC applies the pointer updates and loads the result register.
	typedef enum logic [1:0] {
		IDLE = 2'b01,
		EXEC = 2'b10
	} fsm_t;

	fsm_t  state_q;

	// Request captured at acceptance.
	kind_t              kind_q;
	qidx_t              qidx_q;
	logic               bad_q;
	logic [DATA_W-1:0]  data_q;
	// Slot being worked on: free head for an enqueue, queue head for a dequeue.
	ptr_t               ptr_q;

	// Queue pointer table and free-list head.
	ptr_t head_q [QUEUES];
	ptr_t tail_q [QUEUES];
	ptr_t free_q;

	// Result register.
	logic               out_valid_q;
	status_t            out_status_q;
	logic [DATA_W-1:0]  out_data_q;

	qidx_t              req_qidx;
	logic               req_bad;
	ptr_t               req_ptr;
	logic               accept;
	logic               out_free;
	logic               finish;
	link_req_t          link_req;
	ptr_t               link_rdata;
	logic [DATA_W-1:0]  data_rdata;
	logic               data_we;
	status_t            status;
	logic               op_ok;
	ptr_t               cur_head;
	ptr_t               cur_tail;

	// The queue number field may be wider or narrower than the table index.
	assign req_qidx = QIDX_W'(req.queue_id);
	assign req_bad  = (32'(req.queue_id) >= QUEUES);
	assign req_ptr  = req_bad ? NIL :
			(kind_t'(req.kind) == KIND_DEQ) ? head_q[req_qidx] : free_q;

	assign req.ready = (state_q == IDLE);
	assign accept    = req.valid && req.ready;

	// The result register can take a new word when empty or being drained.
	assign out_free = !out_valid_q || rsp.ready;
	assign finish   = (state_q == EXEC) && out_free;

	assign cur_head = head_q[qidx_q];
	assign cur_tail = tail_q[qidx_q];

	always_comb begin
		if (bad_q) begin
			status = ST_BADQ;
		end else if (!is_slot(ptr_q)) begin
			status = (kind_q == KIND_ENQ) ? ST_FULL : ST_EMPTY;
		end else begin
			status = ST_OK;
		end
	end
	assign op_ok = (status == ST_OK);

	// Link memory traffic. The read is issued at acceptance and consumed in EXEC.
	// An enqueue links the new slot behind a non-empty queue's tail; a dequeue
	// pushes the freed slot onto the free list. The tail's own link is never
	// needed: a dequeue of the tail slot drains the queue by comparing pointers.
	always_comb begin
		link_req       = '0;
		link_req.re    = accept;
		link_req.raddr = req_ptr[SIDX_W-1:0];
		if (finish && op_ok) begin
			if (kind_q == KIND_ENQ) begin
				link_req.we    = is_slot(cur_head) && is_slot(cur_tail);
				link_req.waddr = cur_tail[SIDX_W-1:0];
				link_req.wdata = ptr_q;
			end else begin
				link_req.we    = 1'b1;
				link_req.waddr = ptr_q[SIDX_W-1:0];
				link_req.wdata = free_q;
			end
		end
	end

	mqsb_link_store u_link (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (link_req),
		.rdata (link_rdata)
	);

	// Slot data memory: written by an enqueue, read at acceptance for a dequeue.
	assign data_we = finish && op_ok && (kind_q == KIND_ENQ);

	mqsb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(SLOTS)
	) u_data (
		.clk  (clk),
		.we   (data_we),
		.waddr(ptr_q[SIDX_W-1:0]),
		.wdata(data_q),
		.re   (accept),
		.raddr(req_ptr[SIDX_W-1:0]),
		.rdata(data_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(req.kind);
			qidx_q <= req_qidx;
			bad_q  <= req_bad;
			data_q <= req.data_in;
			ptr_q  <= req_ptr;
		end
	end

	// Pointer writeback. Only an operation that succeeds changes state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
			free_q <= '0;
		end else if (finish && op_ok) begin
			if (kind_q == KIND_ENQ) begin
				free_q <= link_rdata;
				if (!(is_slot(cur_head) && is_slot(cur_tail))) begin
					head_q[qidx_q] <= ptr_q;
				end
				tail_q[qidx_q] <= ptr_q;
			end else begin
				free_q <= ptr_q;
				// Removing the tail slot empties the queue.
				if (ptr_q == cur_tail || !is_slot(link_rdata)) begin
					head_q[qidx_q] <= NIL;
					tail_q[qidx_q] <= NIL;
				end else begin
					head_q[qidx_q] <= link_rdata;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q <= status;
			out_data_q   <= (op_ok && kind_q == KIND_DEQ) ? data_rdata : '0;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.data_out = out_data_q;
endmodule
